@@ sv/srmn_pkg.sv @@
// Package: beat types, register map, state codes and note/velocity tables.
package srmn_pkg;

  typedef struct packed {
    logic        action;
    logic [15:0] address;
    logic [7:0]  value;
  } srmn_in_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] data_one;
    logic [6:0] data_two;
    logic [1:0] byte_count;
    logic       last;
  } srmn_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_TOGGLE,
    S_CH_START,
    S_SEARCH,
    S_EVAL,
    S_CH_OFF,
    S_CH_ON,
    S_FLUSH
  } srmn_state_t;

  localparam logic [15:0] ADDR_VOL0   = 16'h4000;
  localparam logic [15:0] ADDR_LO0    = 16'h4002;
  localparam logic [15:0] ADDR_HI0    = 16'h4003;
  localparam logic [15:0] ADDR_VOL1   = 16'h4004;
  localparam logic [15:0] ADDR_LO1    = 16'h4006;
  localparam logic [15:0] ADDR_HI1    = 16'h4007;
  localparam logic [15:0] ADDR_VOL2   = 16'h4008;
  localparam logic [15:0] ADDR_LO2    = 16'h400A;
  localparam logic [15:0] ADDR_HI2    = 16'h400B;
  localparam logic [15:0] ADDR_VOL3   = 16'h400C;
  localparam logic [15:0] ADDR_PER3   = 16'h400E;
  localparam logic [15:0] ADDR_ENABLE = 16'h4015;

  localparam logic [7:0] MSG_NOTE_ON  = 8'h90;
  localparam logic [7:0] MSG_NOTE_OFF = 8'h80;
  localparam logic [7:0] MSG_PROGRAM  = 8'hC0;

  localparam logic [1:0] LEN_SHORT = 2'd2;
  localparam logic [1:0] LEN_LONG  = 2'd3;

  localparam logic [6:0] NOTE_EDGES  = 7'd106;
  localparam logic [6:0] LOWEST_NOTE = 7'd21;
  localparam logic [1:0] TRI_CH      = 2'd2;
  localparam logic [1:0] LAST_CH     = 2'd3;

  function automatic logic [6:0] program_of(input logic [1:0] c);
    logic [6:0] p;
    unique case (c)
      2'd0:    p = 7'd80;
      2'd1:    p = 7'd81;
      2'd2:    p = 7'd38;
      default: p = 7'd125;
    endcase
    return p;
  endfunction

  // 40 + vol*87/15, zero volume gives zero
  function automatic logic [6:0] velocity_of(input logic [3:0] vol);
    logic [6:0] v;
    unique case (vol)
      4'd0:  v = 7'd0;    4'd1:  v = 7'd45;   4'd2:  v = 7'd51;   4'd3:  v = 7'd57;
      4'd4:  v = 7'd63;   4'd5:  v = 7'd69;   4'd6:  v = 7'd74;   4'd7:  v = 7'd80;
      4'd8:  v = 7'd86;   4'd9:  v = 7'd92;   4'd10: v = 7'd98;   4'd11: v = 7'd103;
      4'd12: v = 7'd109;  4'd13: v = 7'd115;  4'd14: v = 7'd121;  default: v = 7'd127;
    endcase
    return v;
  endfunction

  // upper divisor bound for notes 22..127, decreasing
  function automatic logic [15:0] note_edge(input logic [6:0] i);
    logic [15:0] e;
    unique case (i)
      7'd0:   e = 16'd63229; 7'd1:   e = 16'd59681; 7'd2:   e = 16'd56331;
      7'd3:   e = 16'd53169; 7'd4:   e = 16'd50185; 7'd5:   e = 16'd47368;
      7'd6:   e = 16'd44710; 7'd7:   e = 16'd42200; 7'd8:   e = 16'd39832;
      7'd9:   e = 16'd37596; 7'd10:  e = 16'd35486; 7'd11:  e = 16'd33494;
      7'd12:  e = 16'd31614; 7'd13:  e = 16'd29840; 7'd14:  e = 16'd28165;
      7'd15:  e = 16'd26584; 7'd16:  e = 16'd25092; 7'd17:  e = 16'd23684;
      7'd18:  e = 16'd22355; 7'd19:  e = 16'd21100; 7'd20:  e = 16'd19916;
      7'd21:  e = 16'd18798; 7'd22:  e = 16'd17743; 7'd23:  e = 16'd16747;
      7'd24:  e = 16'd15807; 7'd25:  e = 16'd14920; 7'd26:  e = 16'd14082;
      7'd27:  e = 16'd13292; 7'd28:  e = 16'd12546; 7'd29:  e = 16'd11842;
      7'd30:  e = 16'd11177; 7'd31:  e = 16'd10550; 7'd32:  e = 16'd9958;
      7'd33:  e = 16'd9399;  7'd34:  e = 16'd8871;  7'd35:  e = 16'd8373;
      7'd36:  e = 16'd7903;  7'd37:  e = 16'd7460;  7'd38:  e = 16'd7041;
      7'd39:  e = 16'd6646;  7'd40:  e = 16'd6273;  7'd41:  e = 16'd5921;
      7'd42:  e = 16'd5588;  7'd43:  e = 16'd5275;  7'd44:  e = 16'd4979;
      7'd45:  e = 16'd4699;  7'd46:  e = 16'd4435;  7'd47:  e = 16'd4186;
      7'd48:  e = 16'd3951;  7'd49:  e = 16'd3730;  7'd50:  e = 16'd3520;
      7'd51:  e = 16'd3323;  7'd52:  e = 16'd3136;  7'd53:  e = 16'd2960;
      7'd54:  e = 16'd2794;  7'd55:  e = 16'd2637;  7'd56:  e = 16'd2489;
      7'd57:  e = 16'd2349;  7'd58:  e = 16'd2217;  7'd59:  e = 16'd2093;
      7'd60:  e = 16'd1975;  7'd61:  e = 16'd1865;  7'd62:  e = 16'd1760;
      7'd63:  e = 16'd1661;  7'd64:  e = 16'd1568;  7'd65:  e = 16'd1480;
      7'd66:  e = 16'd1397;  7'd67:  e = 16'd1318;  7'd68:  e = 16'd1244;
      7'd69:  e = 16'd1174;  7'd70:  e = 16'd1108;  7'd71:  e = 16'd1046;
      7'd72:  e = 16'd987;   7'd73:  e = 16'd932;   7'd74:  e = 16'd880;
      7'd75:  e = 16'd830;   7'd76:  e = 16'd784;   7'd77:  e = 16'd740;
      7'd78:  e = 16'd698;   7'd79:  e = 16'd659;   7'd80:  e = 16'd622;
      7'd81:  e = 16'd587;   7'd82:  e = 16'd554;   7'd83:  e = 16'd523;
      7'd84:  e = 16'd493;   7'd85:  e = 16'd466;   7'd86:  e = 16'd440;
      7'd87:  e = 16'd415;   7'd88:  e = 16'd392;   7'd89:  e = 16'd370;
      7'd90:  e = 16'd349;   7'd91:  e = 16'd329;   7'd92:  e = 16'd311;
      7'd93:  e = 16'd293;   7'd94:  e = 16'd277;   7'd95:  e = 16'd261;
      7'd96:  e = 16'd246;   7'd97:  e = 16'd233;   7'd98:  e = 16'd220;
      7'd99:  e = 16'd207;   7'd100: e = 16'd196;   7'd101: e = 16'd185;
      7'd102: e = 16'd174;   7'd103: e = 16'd164;   7'd104: e = 16'd155;
      7'd105: e = 16'd146;   default: e = 16'd0;
    endcase
    return e;
  endfunction

endpackage

@@ sv/sound_register_to_midi_notes_unit.sv @@
// Top level: sound register writes to MIDI note messages, one sequencer and compare unit.
// Flow: a write is decoded and, if ignored, flushed; a toggle steps through all four channels;
// a disabled channel sends its note off, an enabled one runs a binary search over the note edge table.
// Throughput: one beat at a time, one compare per search cycle; an output stall holds the
// sequencer. Messages are held back one beat so the last can be marked.
// Reset (rst, synchronous): mode off, all channel state zero, no beat pending.
module sound_register_to_midi_notes_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  srmn_pkg::srmn_in_t   req_data,
  output logic                 msg_valid,
  input  logic                 msg_ready,
  output srmn_pkg::srmn_out_t  msg_data
);
  import srmn_pkg::*;

  srmn_state_t state, state_next;
  srmn_in_t    inb;

  logic        mode_on;
  logic [10:0] timer_period    [4];
  logic [3:0]  loudness        [4];
  logic [3:0]  channel_enabled;
  logic [6:0]  current_note    [4];
  logic [3:0]  note_playing;

  logic [1:0]  c, c_last;
  logic [6:0]  lo, hi, note;
  srmn_out_t   hold;
  srmn_out_t   hold_tail;
  logic        hold_valid;

  logic        can_push, out_free, emit_en, flush_en, adv;
  srmn_out_t   emit_msg;
  logic [7:0]  mid_sum;
  logic [6:0]  mid;
  logic [11:0] t_inc;
  logic [16:0] m;
  logic [6:0]  vel;
  logic        timer_zero;

  assign req_ready  = (state == S_IDLE);
  assign out_free   = !msg_valid || msg_ready;
  assign can_push   = !hold_valid || out_free;
  assign mid_sum    = {1'b0, lo} + {1'b0, hi};
  assign mid        = mid_sum[7:1];
  assign timer_zero = (timer_period[c] == 11'd0);
  assign t_inc      = {1'b0, timer_period[c]} + 12'd1;
  assign m          = (c == TRI_CH) ? {t_inc, 5'd0} : {1'b0, t_inc, 4'd0};
  assign vel        = velocity_of(loudness[c]);

  always_comb begin
    hold_tail      = hold;
    hold_tail.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    emit_en    = 1'b0;
    flush_en   = 1'b0;
    adv        = 1'b0;
    emit_msg   = '{status_byte: MSG_NOTE_OFF | {6'd0, c}, data_one: current_note[c],
                   data_two: 7'd0, byte_count: LEN_LONG, last: 1'b0};
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (inb.action) begin
          state_next = S_TOGGLE;
        end else if (mode_on && (inb.address == ADDR_VOL0 || inb.address == ADDR_LO0 ||
                     inb.address == ADDR_HI0 || inb.address == ADDR_VOL1 ||
                     inb.address == ADDR_LO1 || inb.address == ADDR_HI1 ||
                     inb.address == ADDR_VOL2 || inb.address == ADDR_LO2 ||
                     inb.address == ADDR_HI2 || inb.address == ADDR_VOL3 ||
                     inb.address == ADDR_PER3 || inb.address == ADDR_ENABLE)) begin
          state_next = S_CH_START;
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_TOGGLE: begin
        if (mode_on) begin
          emit_msg = '{status_byte: MSG_PROGRAM | {6'd0, c}, data_one: program_of(c),
                       data_two: 7'd0, byte_count: LEN_SHORT, last: 1'b0};
          emit_en  = can_push;
          adv      = can_push;
        end else if (note_playing[c]) begin
          emit_en = can_push;
          adv     = can_push;
        end else begin
          adv = 1'b1;
        end
        if (adv) state_next = (c == LAST_CH) ? S_FLUSH : S_TOGGLE;
      end
      S_CH_START: begin
        if (!channel_enabled[c]) begin
          emit_en = note_playing[c] && can_push;
          adv     = !note_playing[c] || can_push;
          if (adv) state_next = (c == c_last) ? S_FLUSH : S_CH_START;
        end else begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (lo >= hi) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (note != current_note[c] && vel != 7'd0) begin
          state_next = note_playing[c] ? S_CH_OFF : S_CH_ON;
        end else begin
          adv        = 1'b1;
          state_next = (c == c_last) ? S_FLUSH : S_CH_START;
        end
      end
      S_CH_OFF: begin
        emit_en = can_push;
        if (can_push) state_next = S_CH_ON;
      end
      S_CH_ON: begin
        if (note != 7'd0) begin
          emit_msg = '{status_byte: MSG_NOTE_ON | {6'd0, c}, data_one: note,
                       data_two: vel, byte_count: LEN_LONG, last: 1'b0};
          emit_en  = can_push;
          adv      = can_push;
        end else begin
          adv = 1'b1;
        end
        if (adv) state_next = (c == c_last) ? S_FLUSH : S_CH_START;
      end
      S_FLUSH: begin
        flush_en = hold_valid && out_free;
        if (!hold_valid || out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // output beat register and one-deep hold stage
  always_ff @(posedge clk) begin
    if (rst) begin
      msg_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (emit_en) begin
        hold       <= emit_msg;
        hold_valid <= 1'b1;
      end else if (flush_en) begin
        hold_valid <= 1'b0;
      end
      if ((emit_en && hold_valid) || flush_en) begin
        msg_data  <= flush_en ? hold_tail : hold;
        msg_valid <= 1'b1;
      end else if (msg_ready) begin
        msg_valid <= 1'b0;
      end
    end
  end

  // channel state and sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_on         <= 1'b0;
      channel_enabled <= 4'd0;
      note_playing    <= 4'd0;
      for (int i = 0; i < 4; i++) begin
        timer_period[i] <= 11'd0;
        loudness[i]     <= 4'd0;
        current_note[i] <= 7'd0;
      end
    end else begin
      if (req_valid && req_ready) inb <= req_data;
      if (adv) c <= c + 2'd1;
      unique case (state)
        S_DECODE: begin
          if (inb.action) begin
            mode_on <= !mode_on;
            c       <= 2'd0;
            c_last  <= LAST_CH;
          end else if (mode_on) begin
            unique case (inb.address)
              ADDR_VOL0: begin loudness[0] <= inb.value[3:0]; c <= 2'd0; c_last <= 2'd0; end
              ADDR_LO0:  begin timer_period[0][7:0] <= inb.value; c <= 2'd0; c_last <= 2'd0; end
              ADDR_HI0:  begin
                timer_period[0][10:8] <= inb.value[2:0]; c <= 2'd0; c_last <= 2'd0;
              end
              ADDR_VOL1: begin loudness[1] <= inb.value[3:0]; c <= 2'd1; c_last <= 2'd1; end
              ADDR_LO1:  begin timer_period[1][7:0] <= inb.value; c <= 2'd1; c_last <= 2'd1; end
              ADDR_HI1:  begin
                timer_period[1][10:8] <= inb.value[2:0]; c <= 2'd1; c_last <= 2'd1;
              end
              ADDR_VOL2: begin
                loudness[2] <= {4{inb.value[7]}}; c <= 2'd2; c_last <= 2'd2;
              end
              ADDR_LO2:  begin timer_period[2][7:0] <= inb.value; c <= 2'd2; c_last <= 2'd2; end
              ADDR_HI2:  begin
                timer_period[2][10:8] <= inb.value[2:0]; c <= 2'd2; c_last <= 2'd2;
              end
              ADDR_VOL3: begin loudness[3] <= inb.value[3:0]; c <= 2'd3; c_last <= 2'd3; end
              ADDR_PER3: begin
                timer_period[3] <= {7'd0, inb.value[3:0]}; c <= 2'd3; c_last <= 2'd3;
              end
              ADDR_ENABLE: begin
                channel_enabled <= inb.value[3:0]; c <= 2'd0; c_last <= LAST_CH;
              end
              default: ;
            endcase
          end
        end
        S_TOGGLE: begin
          if (emit_en && !mode_on) note_playing[c] <= 1'b0;
        end
        S_CH_START: begin
          if (emit_en) note_playing[c] <= 1'b0;
          lo <= 7'd0;
          hi <= timer_zero ? 7'd0 : NOTE_EDGES;
        end
        S_SEARCH: begin
          if (lo < hi) begin
            if (m <= {1'b0, note_edge(mid)}) lo <= mid + 7'd1;
            else                             hi <= mid;
          end else begin
            note <= timer_zero ? 7'd0 : LOWEST_NOTE + lo;
          end
        end
        S_CH_ON: begin
          if (adv) begin
            if (note != 7'd0) begin
              note_playing[c] <= 1'b1;
              current_note[c] <= note;
            end else begin
              note_playing[c] <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
